// ===== hdl/bf3_pkg.sv =====
package bf3_pkg;

  // Frame geometry.
  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = 11;
  localparam int COL_W   = $clog2(MAX_DIM);

  // Pixel and arithmetic widths.
  localparam int CH_W    = 16;
  localparam int PIX_W   = 3 * CH_W;
  localparam int TAPS    = 9;
  localparam int SUM_W   = CH_W + 4;
  localparam int MULT_W  = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MULT_W;

  // Reciprocal constants for exact truncated division of a SUM_W-bit value.
  localparam logic [MULT_W-1:0] DIV3_MULT  = MULT_W'(1398102);
  localparam int                DIV3_SHIFT = 22;
  localparam logic [MULT_W-1:0] DIV9_MULT  = MULT_W'(1864136);
  localparam int                DIV9_SHIFT = 24;

  // Result queue geometry.
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // Divisor codes: the number of neighborhood pixels inside the frame.
  typedef logic [2:0] div_code_t;
  localparam div_code_t DIV_1 = 3'd0;
  localparam div_code_t DIV_2 = 3'd1;
  localparam div_code_t DIV_3 = 3'd2;
  localparam div_code_t DIV_4 = 3'd3;
  localparam div_code_t DIV_6 = 3'd4;
  localparam div_code_t DIV_9 = 3'd5;

  // Input item.
  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } pix_t;

  // Result item.
  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } res_t;

  // Control that travels alongside the datapath for one result.
  typedef struct packed {
    logic            valid;
    logic            frame_end;
    logic [TAPS-1:0] mask;
    div_code_t       code;
  } ctl_t;

  // Window taps, indexed row * 3 + column; row 0 is the oldest row.
  typedef logic [TAPS-1:0][PIX_W-1:0] window_t;
  typedef logic [TAPS-1:0][CH_W-1:0]  lane_taps_t;

  // Divisor code from the number of valid neighbor rows and columns.
  function automatic div_code_t div_code(input logic row_lo, input logic row_hi,
                                         input logic col_lo, input logic col_hi);
    logic [1:0] nr;
    logic [1:0] nc;
    div_code_t  code;
    nr = 2'(row_lo) + 2'(row_hi);
    nc = 2'(col_lo) + 2'(col_hi);
    unique case ({nr, nc})
      4'b0000:          code = DIV_1;
      4'b0001, 4'b0100: code = DIV_2;
      4'b0010, 4'b1000: code = DIV_3;
      4'b0101:          code = DIV_4;
      4'b0110, 4'b1001: code = DIV_6;
      4'b1010:          code = DIV_9;
      default:          code = DIV_1;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/box_filter_three_by_three.sv =====
// 3x3 box filter for a square RGB frame streamed in raster order.
// The frame side is written on the cfg channel (cfg_valid, cfg_ready,
// cfg_data); cfg_ready is always high, a write of 0 is taken as 1, a value
// above 1024 as 1024, and any write restarts the frame.
// Pixels enter on the pix channel and results leave on the res channel;
// a transfer happens on a clock edge with valid high and stall low.
// After the last pixel of a frame, frame_dim + 1 drain items (op = 1, or
// pixel items whose values are dropped) flush the remaining results; the
// last result carries frame_end. Drain items sent early are dropped.
// Throughput is one item per cycle while pix_stall is low. A result
// becomes visible on res after the transfer of the item that completes
// its window: the line store is read at the transfer edge, then the window
// update, the sum, the reciprocal multiply and the queue write are registered.
// The result queue holds 8 results; pix_stall rises only when 8 results
// are accepted but not yet taken, so a stall on res reaches the input
// after the queue fills.
// Synchronous reset sets frame_dim to 1, clears the frame position and
// empties the queue. The line stores are not cleared; entries not yet
// written in a frame only feed taps outside the frame.
module box_filter_three_by_three (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bf3_pkg::DIM_W-1:0] cfg_data,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  bf3_pkg::pix_t             pix,
  output logic                      res_valid,
  input  logic                      res_stall,
  output bf3_pkg::res_t             res
);
  import bf3_pkg::*;

  logic [DIM_W-1:0] frame_dim;
  logic [DIM_W-1:0] dim_next;
  logic [DIM_W-1:0] dim_less;
  logic [COL_W-1:0] dim_m1;
  logic [COL_W-1:0] col_in;
  logic [DIM_W-1:0] row_in;
  logic [COL_W-1:0] out_col;
  logic [COL_W-1:0] out_row;

  logic             accept;
  logic             pixel_phase;
  logic             take;
  logic             have_out;
  logic             last_out;
  logic [PIX_W-1:0] px;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  ctl_t             ctl_next;
  ctl_t             ctl_s1;
  ctl_t             ctl_s2;
  ctl_t             ctl_s3;
  ctl_t             ctl_s4;
  window_t          window;
  lane_taps_t       lane_taps [3];
  logic [CH_W-1:0]  lane_mean [3];
  logic             full;

  assign cfg_ready = 1'b1;
  assign pix_stall = full;
  assign accept    = pix_valid && !pix_stall;

  // Position decode for the item at the input.
  always_comb begin
    dim_less    = frame_dim - DIM_W'(1);
    dim_m1      = dim_less[COL_W-1:0];
    pixel_phase = (row_in < frame_dim);
    take        = accept && !(pixel_phase && pix.op);
    have_out    = (row_in >= DIM_W'(2)) || ((row_in == DIM_W'(1)) && (col_in != '0));
    last_out    = (out_row == dim_m1) && (out_col == dim_m1);
    px          = pixel_phase ? {pix.in_blue, pix.in_green, pix.in_red} : '0;
  end

  // Neighborhood mask and divisor for the result due with this item.
  always_comb begin
    row_ok = {out_row != dim_m1, 1'b1, out_row != '0};
    col_ok = {out_col != dim_m1, 1'b1, out_col != '0};
    ctl_next.valid     = take && have_out;
    ctl_next.frame_end = last_out;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ctl_next.mask[r*3 + c] = row_ok[r] && col_ok[c];
      end
    end
    ctl_next.code = div_code(row_ok[0], row_ok[2], col_ok[0], col_ok[2]);
  end

  // Clamp a written frame side into range.
  always_comb begin
    if (cfg_data == '0) begin
      dim_next = DIM_W'(1);
    end else if (cfg_data > DIM_W'(MAX_DIM)) begin
      dim_next = DIM_W'(MAX_DIM);
    end else begin
      dim_next = cfg_data;
    end
  end

  // Frame side and input and output positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_dim <= DIM_W'(1);
      col_in    <= '0;
      row_in    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frame_dim <= dim_next;
      col_in    <= '0;
      row_in    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (take) begin
      if (have_out && last_out) begin
        col_in  <= '0;
        row_in  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col_in == dim_m1) begin
          col_in <= '0;
          row_in <= row_in + 1'b1;
        end else begin
          col_in <= col_in + 1'b1;
        end
        if (have_out) begin
          if (out_col == dim_m1) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // Control pipeline matched to the line store and lane latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1 <= '0;
      ctl_s2 <= '0;
      ctl_s3 <= '0;
      ctl_s4 <= '0;
    end else begin
      ctl_s1 <= ctl_next;
      ctl_s2 <= ctl_s1;
      ctl_s3 <= ctl_s2;
      ctl_s4 <= ctl_s3;
    end
  end

  bf3_line_store u_line_store (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .col    (col_in),
    .px     (px),
    .window (window)
  );

  // One lane per color channel.
  always_comb begin
    for (int g = 0; g < 3; g++) begin
      for (int t = 0; t < TAPS; t++) begin
        lane_taps[g][t] = window[t][g*CH_W +: CH_W];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    bf3_lane u_lane (
      .clk  (clk),
      .taps (lane_taps[g]),
      .mask (ctl_s2.mask),
      .code (ctl_s2.code),
      .mean (lane_mean[g])
    );
  end

  bf3_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .reserve   (ctl_next.valid),
    .push      (ctl_s4.valid),
    .red       (lane_mean[0]),
    .green     (lane_mean[1]),
    .blue      (lane_mean[2]),
    .frame_end (ctl_s4.frame_end),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .full      (full)
  );

endmodule

// ===== hdl/bf3_line_store.sv =====
module bf3_line_store (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [bf3_pkg::COL_W-1:0] col,
  input  logic [bf3_pkg::PIX_W-1:0] px,
  output bf3_pkg::window_t        window
);
  import bf3_pkg::*;

  // Each entry holds the older row in the upper half and the newer row below.
  logic [2*PIX_W-1:0] rows [MAX_DIM];

  logic               s1_valid;
  logic [COL_W-1:0]   s1_col;
  logic [PIX_W-1:0]   s1_px;
  logic [2*PIX_W-1:0] rdata;
  logic               byp;
  logic [2*PIX_W-1:0] byp_data;
  logic [2*PIX_W-1:0] entry;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;
  logic [2*PIX_W-1:0] wdata;

  // Stage valid for the item whose rows are being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  // Registered read; a read of the column written in the same cycle takes
  // the write data instead.
  always_ff @(posedge clk) begin
    if (take) begin
      rdata    <= rows[col];
      s1_col   <= col;
      s1_px    <= px;
      byp      <= s1_valid && (s1_col == col);
      byp_data <= wdata;
    end
    if (s1_valid) begin
      rows[s1_col] <= wdata;
    end
  end

  // The newer row moves up and the new pixel becomes the newer row.
  always_comb begin
    entry = byp ? byp_data : rdata;
    top   = entry[2*PIX_W-1:PIX_W];
    mid   = entry[PIX_W-1:0];
    wdata = {mid, s1_px};
  end

  // Window columns shift left; the new column enters on the right.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        window[r*3]     <= window[r*3 + 1];
        window[r*3 + 1] <= window[r*3 + 2];
      end
      window[2] <= top;
      window[5] <= mid;
      window[8] <= s1_px;
    end
  end

endmodule

// ===== hdl/bf3_lane.sv =====
module bf3_lane (
  input  logic                      clk,
  input  bf3_pkg::lane_taps_t       taps,
  input  logic [bf3_pkg::TAPS-1:0]  mask,
  input  bf3_pkg::div_code_t        code,
  output logic [bf3_pkg::CH_W-1:0]  mean
);
  import bf3_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  opnd_next;
  logic [SUM_W-1:0]  opnd;
  div_code_t         code_a;
  logic [MULT_W-1:0] mult;
  logic [PROD_W-1:0] prod;
  div_code_t         code_b;

  // Masked sum of the neighborhood, with the power-of-two part of the
  // divisor applied as a shift.
  always_comb begin
    sum = '0;
    for (int t = 0; t < TAPS; t++) begin
      if (mask[t]) begin
        sum = sum + SUM_W'(taps[t]);
      end
    end
    unique case (code)
      DIV_2, DIV_6: opnd_next = sum >> 1;
      DIV_4:        opnd_next = sum >> 2;
      default:      opnd_next = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    opnd   <= opnd_next;
    code_a <= code;
  end

  // Odd part of the divisor as a multiply by its reciprocal.
  always_comb begin
    unique case (code_a)
      DIV_3, DIV_6: mult = DIV3_MULT;
      DIV_9:        mult = DIV9_MULT;
      default:      mult = MULT_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    prod   <= PROD_W'(opnd) * PROD_W'(mult);
    code_b <= code_a;
  end

  // Drop the fraction bits of the reciprocal product.
  always_comb begin
    unique case (code_b)
      DIV_3, DIV_6: mean = prod[DIV3_SHIFT +: CH_W];
      DIV_9:        mean = prod[DIV9_SHIFT +: CH_W];
      default:      mean = prod[CH_W-1:0];
    endcase
  end

endmodule

// ===== hdl/bf3_out_queue.sv =====
module bf3_out_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     reserve,
  input  logic                     push,
  input  logic [bf3_pkg::CH_W-1:0] red,
  input  logic [bf3_pkg::CH_W-1:0] green,
  input  logic [bf3_pkg::CH_W-1:0] blue,
  input  logic                     frame_end,
  output logic                     res_valid,
  input  logic                     res_stall,
  output bf3_pkg::res_t            res,
  output logic                     full
);
  import bf3_pkg::*;

  res_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic [Q_CNT_W-1:0] occ;
  logic               pop;
  res_t               merged;

  // Merge the lane results into one result item.
  always_comb begin
    merged.out_red   = red;
    merged.out_green = green;
    merged.out_blue  = blue;
    merged.frame_end = frame_end;
  end

  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != '0);
  assign res       = entries[rd_ptr];
  // Slots are reserved when an item that yields a result is accepted, so
  // the pipeline never has to wait for the receiver.
  assign full      = (occ == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= merged;
    end
  end

  // Pointers, stored count and reserved count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
      occ   <= occ + Q_CNT_W'(reserve) - Q_CNT_W'(pop);
    end
  end

endmodule
